@@ sv/arbh_pkg.sv @@
package arbh_pkg;

  // 128-bit hash seed as written through the register port
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } seed_t;

  localparam int unsigned ChunkBytes = 16;
  localparam int unsigned StateW     = 8 * ChunkBytes;

  // register byte addresses
  localparam logic [3:0] AddrSeedLow  = 4'h0;
  localparam logic [3:0] AddrSeedHigh = 4'h8;

  // default seed, bytes 0 to 15
  localparam logic [63:0] SeedLowReset  = 64'hD88F_2928_F05F_C9B2;
  localparam logic [63:0] SeedHighReset = 64'hBCB0_04E8_72B2_D102;

  // inverse aes substitution box
  localparam logic [7:0] InvSbox [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gf_mul9 = a8 ^ a;
  endfunction

  function automatic logic [7:0] gf_mul11(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gf_mul11 = a8 ^ a2 ^ a;
  endfunction

  function automatic logic [7:0] gf_mul13(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gf_mul13 = a8 ^ a4 ^ a;
  endfunction

  function automatic logic [7:0] gf_mul14(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gf_mul14 = a8 ^ a4 ^ a2;
  endfunction

endpackage

@@ sv/arbh_inv_round.sv @@
module arbh_inv_round import arbh_pkg::*; (
  input  logic [StateW-1:0] state_i,  // byte i in bits 8i+7:8i
  output logic [StateW-1:0] state_o
);

  logic [7:0] sub_b [ChunkBytes];

  // inverse shift rows and inverse substitution
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_b[r + 4 * c] = InvSbox[state_i[8 * (r + 4 * ((c - r + 4) % 4)) +: 8]];
      end
    end
  end

  // inverse mix columns, zero round key
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      state_o[8 * (4 * c) +: 8] = gf_mul14(sub_b[4 * c]) ^ gf_mul11(sub_b[4 * c + 1])
                                ^ gf_mul13(sub_b[4 * c + 2]) ^ gf_mul9(sub_b[4 * c + 3]);
      state_o[8 * (4 * c + 1) +: 8] = gf_mul9(sub_b[4 * c]) ^ gf_mul14(sub_b[4 * c + 1])
                                    ^ gf_mul11(sub_b[4 * c + 2]) ^ gf_mul13(sub_b[4 * c + 3]);
      state_o[8 * (4 * c + 2) +: 8] = gf_mul13(sub_b[4 * c]) ^ gf_mul9(sub_b[4 * c + 1])
                                    ^ gf_mul14(sub_b[4 * c + 2]) ^ gf_mul11(sub_b[4 * c + 3]);
      state_o[8 * (4 * c + 3) +: 8] = gf_mul11(sub_b[4 * c]) ^ gf_mul13(sub_b[4 * c + 1])
                                    ^ gf_mul9(sub_b[4 * c + 2]) ^ gf_mul14(sub_b[4 * c + 3]);
    end
  end

endmodule

@@ sv/arbh_absorb.sv @@
module arbh_absorb import arbh_pkg::*; (
  input  logic [StateW-1:0] state_i,
  input  logic [StateW-1:0] block_i,
  output logic [StateW-1:0] state_o
);

  localparam int unsigned Rounds = 4;

  logic [StateW-1:0] stage [Rounds+1];

  // xor the block in, then four unrolled rounds
  assign stage[0] = state_i ^ block_i;

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    arbh_inv_round u_round (
      .state_i (stage[g]),
      .state_o (stage[g+1])
    );
  end

  assign state_o = stage[Rounds];

endmodule

@@ sv/arbh_cfg_regs.sv @@
module arbh_cfg_regs import arbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output seed_t       seed_o
);

  logic [63:0] seed_low_q, seed_low_d;
  logic [63:0] seed_high_q, seed_high_d;
  logic        wr_en;
  logic        sel_high;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign sel_high = paddr[3] == AddrSeedHigh[3];

  // write decode on the register select bit
  always_comb begin
    seed_low_d  = seed_low_q;
    seed_high_d = seed_high_q;
    if (wr_en) begin
      if (sel_high) begin
        seed_high_d = pwdata;
      end else begin
        seed_low_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= SeedLowReset;
      seed_high_q <= SeedHighReset;
    end else begin
      seed_low_q  <= seed_low_d;
      seed_high_q <= seed_high_d;
    end
  end

  // read back
  assign prdata = sel_high ? seed_high_q : seed_low_q;

  assign seed_o.low  = seed_low_q;
  assign seed_o.high = seed_high_q;

endmodule

@@ sv/aes_round_block_hash.sv @@
// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: start_req; tdata: length, chunk
// m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: hash_low, hash_high
// apb      | in  | psel/penable, pready high   | seed_low at 0x0, seed_high at 0x8
//
// one item per cycle while no tail item waits for a full output register; an item sits in the input register,
// where the xor and four unrolled inverse aes rounds update the hash state.
// the hash appears in the output register the cycle after its tail item.
// reset restores the default seed and leaves no message in progress.
// the input register holds only while a tail item waits for a full output register.
module aes_round_block_hash import arbh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // message_length[63:0], chunk_low, chunk_high
  input  logic [0:0]   s_axis_tuser,  // start_req
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // hash_low[63:0], hash_high
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  seed_t seed;

  arbh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed_o  (seed)
  );

  // input register
  logic              in_valid_q, in_valid_d;
  logic              in_start_q;
  logic [63:0]       in_len_q;
  logic [StateW-1:0] in_chunk_q;
  logic              s_fire;
  logic              advance;

  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_start_q <= s_axis_tuser[0];
      in_len_q   <= s_axis_tdata[63:0];
      in_chunk_q <= s_axis_tdata[191:64];
    end
  end

  // message state
  logic [StateW-1:0] hash_q, hash_d;
  logic [59:0]       left_q, left_d;
  logic [3:0]        tail_q, tail_d;
  logic              active_q, active_d;

  logic [StateW-1:0] cur_hash;
  logic [59:0]       cur_left;
  logic [3:0]        cur_tail;
  logic              cur_active;
  logic              is_tail;
  logic [StateW-1:0] tail_mask;
  logic [StateW-1:0] block;
  logic [StateW-1:0] absorbed;
  logic              need_out;
  logic              out_free;
  logic              emit;

  // a start item reloads the state from the length and seed
  always_comb begin
    if (in_start_q) begin
      cur_hash   = {seed.high, in_len_q ^ seed.low};
      cur_left   = in_len_q[63:4];
      cur_tail   = in_len_q[3:0];
      cur_active = 1'b1;
    end else begin
      cur_hash   = hash_q;
      cur_left   = left_q;
      cur_tail   = tail_q;
      cur_active = active_q;
    end
  end

  // keep only the low tail bytes
  always_comb begin
    for (int b = 0; b < ChunkBytes; b++) begin
      tail_mask[8 * b +: 8] = {8{4'(b) < cur_tail}};
    end
  end

  assign is_tail = cur_left == '0;
  assign block   = is_tail ? (in_chunk_q & tail_mask) : in_chunk_q;

  arbh_absorb u_absorb (
    .state_i (cur_hash),
    .block_i (block),
    .state_o (absorbed)
  );

  // handshake between the input and output registers
  assign need_out = in_valid_q && cur_active && is_tail;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = in_valid_q && (!need_out || out_free);
  assign emit     = advance && need_out;

  always_comb begin
    hash_d   = hash_q;
    left_d   = left_q;
    tail_d   = tail_q;
    active_d = active_q;
    if (advance && cur_active) begin
      hash_d   = absorbed;
      left_d   = is_tail ? '0 : cur_left - 60'd1;
      tail_d   = cur_tail;
      active_d = !is_tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      left_q   <= '0;
      tail_q   <= '0;
      active_q <= 1'b0;
    end else begin
      hash_q   <= hash_d;
      left_q   <= left_d;
      tail_q   <= tail_d;
      active_q <= active_d;
    end
  end

  // output register
  logic              out_valid_q, out_valid_d;
  logic [StateW-1:0] out_hash_q;

  assign out_valid_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_hash_q <= absorbed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hash_q;

  // checks
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("result appeared without a tail item");

  a_emit_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !active_q)
    else $error("message still active after its hash");

  a_left_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q != '0) |-> active_q)
    else $error("chunks pending with no message in progress");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && need_out && !out_free))
    else $error("input stalled without a blocked tail item");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import arbh_pkg::*; ();

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned PhaseItems = 350;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned MaxPrinted = 40;

  // one row of the directed stimulus
  typedef struct packed {
    logic        start;
    logic [63:0] len;
    logic [63:0] lo;
    logic [63:0] hi;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;  // message_length[63:0], chunk_low, chunk_high
  logic [0:0]   s_axis_tuser;  // start_req
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;  // hash_low[63:0], hash_high
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  aes_round_block_hash u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // hash model state, seeds follow the register writes seen on the bus
  logic [63:0]  seed_lo;
  logic [63:0]  seed_hi;
  logic [127:0] run_state;
  logic [59:0]  chunks_left;
  logic [3:0]   tail_bytes;
  bit           msg_open;

  logic [127:0] pending_hashes [$];
  logic [127:0] want_hash;
  logic [127:0] new_hash;

  int unsigned err_count;
  int unsigned n_items;
  int unsigned n_used;
  int unsigned n_ignored;
  int unsigned n_abandoned;
  int unsigned n_hashes;
  int unsigned n_writes;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          hold_request;
  bit          hold_seen;

  task automatic report_mismatch(input string what);
    if (err_count < MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // gf(2^8) product, shift and add
  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    acc = '0;
    x = a;
    y = b;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) acc ^= x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
      y = y >> 1;
    end
    return acc;
  endfunction

  // inverse shift rows, inverse sub bytes, inverse mix columns, zero key
  function automatic logic [127:0] inv_aes_round(input logic [127:0] s);
    logic [7:0]   t [16];
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[k + 4 * c] = InvSbox[s[8 * (k + 4 * ((c - k + 4) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      r[8 * (4 * c) +: 8] =
        gf_prod(a0, 8'd14) ^ gf_prod(a1, 8'd11) ^ gf_prod(a2, 8'd13) ^ gf_prod(a3, 8'd9);
      r[8 * (4 * c + 1) +: 8] =
        gf_prod(a0, 8'd9) ^ gf_prod(a1, 8'd14) ^ gf_prod(a2, 8'd11) ^ gf_prod(a3, 8'd13);
      r[8 * (4 * c + 2) +: 8] =
        gf_prod(a0, 8'd13) ^ gf_prod(a1, 8'd9) ^ gf_prod(a2, 8'd14) ^ gf_prod(a3, 8'd11);
      r[8 * (4 * c + 3) +: 8] =
        gf_prod(a0, 8'd11) ^ gf_prod(a1, 8'd13) ^ gf_prod(a2, 8'd9) ^ gf_prod(a3, 8'd14);
    end
    return r;
  endfunction

  // xor a block into the running state, then four rounds
  function automatic logic [127:0] fold_block(input logic [127:0] st, input logic [127:0] blk);
    logic [127:0] s;
    s = st ^ blk;
    for (int i = 0; i < 4; i++) s = inv_aes_round(s);
    return s;
  endfunction

  // advance the hash model by one item, returns 1 when a hash comes out
  function automatic bit hash_item(input logic start, input logic [63:0] len,
                                   input logic [63:0] lo, input logic [63:0] hi,
                                   output logic [127:0] digest);
    logic [127:0] blk;
    blk = {hi, lo};
    digest = '0;
    if (start) begin
      if (msg_open) n_abandoned++;
      run_state   = {seed_hi, len ^ seed_lo};
      chunks_left = len[63:4];
      tail_bytes  = len[3:0];
      msg_open    = 1'b1;
    end else if (!msg_open) begin
      n_ignored++;
      return 1'b0;
    end
    n_used++;
    if (chunks_left != '0) begin
      run_state = fold_block(run_state, blk);
      chunks_left--;
      return 1'b0;
    end
    // tail: keep only the low tail_bytes bytes
    blk &= (128'h1 << (8 * tail_bytes)) - 128'h1;
    run_state = fold_block(run_state, blk);
    msg_open = 1'b0;
    digest = run_state;
    return 1'b1;
  endfunction

  // bus monitor: checks hashes, predicts on accepted items, tracks seeds
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_hashes++;
        if (pending_hashes.size() == 0) begin
          report_mismatch($sformatf("hash %h with no message finished", m_axis_tdata));
        end else begin
          want_hash = pending_hashes.pop_front();
          if (m_axis_tdata[63:0] !== want_hash[63:0])
            report_mismatch($sformatf("hash_low %h, want %h", m_axis_tdata[63:0],
                                      want_hash[63:0]));
          if (m_axis_tdata[127:64] !== want_hash[127:64])
            report_mismatch($sformatf("hash_high %h, want %h", m_axis_tdata[127:64],
                                      want_hash[127:64]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_items++;
        if (hash_item(s_axis_tuser[0], s_axis_tdata[63:0], s_axis_tdata[127:64],
                      s_axis_tdata[191:128], new_hash))
          pending_hashes.push_back(new_hash);
      end
      if (psel && penable && pwrite && pready) begin
        n_writes++;
        if (paddr == AddrSeedLow) seed_lo = pwdata;
        else if (paddr == AddrSeedHigh) seed_hi = pwdata;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver: changing ready pattern, plus one long hold on request
  initial begin : rx_side
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase_cnt;
    mode = 0;
    mode_left = 0;
    phase_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase_cnt++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= phase_cnt[2];
        endcase
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one item, in bursts with random gaps; returns once accepted
  task automatic offer_item(input logic start, input logic [63:0] len,
                            input logic [63:0] lo, input logic [63:0] hi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {hi, lo, len};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // idle cycle first so back to back accesses never drive psel twice at one edge
  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input logic [3:0] addr, input logic [63:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("read at %h gave %h, want %h", addr, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drain outstanding hashes, let the block settle, then load a new seed
  task automatic load_seed(input logic [63:0] lo, input logic [63:0] hi);
    s_axis_tvalid <= 1'b0;
    // let the monitor see the last accepted item first
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    reg_write(AddrSeedLow, lo);
    reg_write(AddrSeedHigh, hi);
    burst_left = 0;
  endtask

  // one message: start item carrying the length, then chunks and tail
  task automatic send_message(input logic [63:0] len, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) offer_item(i == 0, len, rand64(), rand64());
  endtask

  stim_row_t dir_rows [19] = '{
    // chunk with no message open is dropped
    '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    // short messages: the start item is the tail
    '{1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b1, 64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b1, 64'd8, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
    '{1'b1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
    '{1'b1, 64'd9, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF},
    // one full chunk, then a tail keeping no bytes
    '{1'b1, 64'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    // two full chunks
    '{1'b1, 64'd32, 64'h0, 64'h0},
    '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5},
    // largest length, never finishes, cut short by a new start
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0},
    '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b1, 64'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    // dropped again after a finished message
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0},
    // tail keeping fifteen bytes
    '{1'b1, 64'd31, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0},
    '{1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    // left open across the next seed change
    '{1'b1, 64'd40, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF}
  };

  logic [63:0] phase_seed_lo [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                                     64'hD88F_2928_F05F_C9B2};
  logic [63:0] phase_seed_hi [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                                     64'hBCB0_04E8_72B2_D102};

  // main sequence
  initial begin : stimulus
    int unsigned pick;
    int unsigned goal;
    logic [63:0] len;
    // hash model after reset
    seed_lo     = 64'hD88F_2928_F05F_C9B2;
    seed_hi     = 64'hBCB0_04E8_72B2_D102;
    run_state   = '0;
    chunks_left = '0;
    tail_bytes  = '0;
    msg_open    = 1'b0;
    burst_left  = 0;
    // known values on every input from the start
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default seed after reset
    reg_check(AddrSeedLow, seed_lo);
    reg_check(AddrSeedHigh, seed_hi);

    // directed rows
    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].start, dir_rows[i].len, dir_rows[i].lo, dir_rows[i].hi);
    end

    // random phases, each under its own seed
    phase_seed_lo[2] = rand64();
    phase_seed_hi[2] = rand64();
    for (int p = 0; p < 4; p++) begin
      load_seed(phase_seed_lo[p], phase_seed_hi[p]);
      if (p == 0) begin
        reg_check(AddrSeedLow, seed_lo);
        reg_check(AddrSeedHigh, seed_hi);
        // finish the open message under the new seed
        offer_item(1'b0, rand64(), rand64(), rand64());
        offer_item(1'b0, rand64(), rand64(), rand64());
      end
      if (p == 2) hold_request = 1'b1;
      goal = n_used + PhaseItems;
      while (n_used < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // well formed, mostly short
          len = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 1023)) :
                                               64'($urandom_range(0, 159));
          send_message(len, 32'(len[63:4]) + 32'd1);
        end else if (pick < 90) begin
          // start with a wild length, cut short by whatever comes next
          send_message(rand64(), $urandom_range(1, 4));
        end else begin
          // stray chunks
          repeat ($urandom_range(1, 3)) offer_item(1'b0, rand64(), rand64(), rand64());
        end
      end
    end

    // wait for the last hashes, then let the block settle
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("run: %0d items in, %0d hashes out, %0d register writes",
             n_items, n_hashes, n_writes);
    $display("run: %0d stray chunks dropped, %0d messages cut short, long output hold %s",
             n_ignored, n_abandoned, hold_seen ? "done" : "missed");
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
